// File: rtl/hrpt_pkg.sv
// Shared types and constants for the half-plane region point test block.
// Request/response beats, direction table rows, command and sequencer codes.
// No dependencies.
`default_nettype none

package hrpt_pkg;

   localparam int VAL_W      = 16;
   localparam int NDIR_W     = 5;
   localparam int NCOV_W     = 4;
   localparam int DOT_W      = 2 * VAL_W + 1;   // sum of two 16x16 products
   localparam int OPA_W      = VAL_W;
   localparam int OPB_W      = DOT_W;
   localparam int PROD_W     = OPA_W + OPB_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_DIRECTIONS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COVARIATES = 2'd1;

   typedef enum logic [1:0] {
      CMD_LOAD_DIR  = 2'd0,
      CMD_LOAD_COEF = 2'd1,
      CMD_LOAD_COV  = 2'd2,
      CMD_TEST      = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [3:0]               dir_index;
      logic [2:0]               cov_index;
      logic signed [VAL_W-1:0]  dir_x;
      logic signed [VAL_W-1:0]  dir_y;
      logic signed [VAL_W-1:0]  orth_x;
      logic signed [VAL_W-1:0]  orth_y;
      logic signed [VAL_W-1:0]  eff_gain;
      logic signed [VAL_W-1:0]  coef_value;
      logic signed [VAL_W-1:0]  point_x;
      logic signed [VAL_W-1:0]  point_y;
   } req_type;

   typedef struct packed {
      logic               inside_res;
      logic [NDIR_W-1:0]  directions_examined;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]  dir_x;
      logic signed [VAL_W-1:0]  dir_y;
      logic signed [VAL_W-1:0]  orth_x;
      logic signed [VAL_W-1:0]  orth_y;
      logic signed [VAL_W-1:0]  eff_gain;
   } dir_row_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MUL   = 5'b00010,
      S_DRAIN = 5'b00100,
      S_CMP   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   // Destination of the product leaving the shared multiplier.
   typedef enum logic [2:0] {
      TAG_NONE = 3'd0,
      TAG_A    = 3'd1,
      TAG_B    = 3'd2,
      TAG_G    = 3'd3,
      TAG_C    = 3'd4
   } tag_type;

endpackage

`default_nettype wire

// File: rtl/hrpt_mul.sv
// Shared signed multiplier with a registered product.
// Depends on hrpt_pkg for operand and product widths.
`default_nettype none

module hrpt_mul (
   input  logic                                clock,
   input  logic signed [hrpt_pkg::OPA_W-1:0]   op_a,
   input  logic signed [hrpt_pkg::OPB_W-1:0]   op_b,
   output logic signed [hrpt_pkg::PROD_W-1:0]  prod_ff
);
   import hrpt_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// File: rtl/halfplane_region_point_test_top.sv
// Half-plane region point test: top level with tables, sequencer and checks.
// Depends on hrpt_pkg and hrpt_mul.
//
// Usage:
//  - req channel (valid/ready) carries one beat per command. Load commands
//    write the direction table, the coefficient table or the covariate
//    vector; loads with an index past the table are dropped. A test command
//    carries a point and yields one rsp beat.
//  - csr channel writes num_directions (index 0) and num_covariates
//    (index 1); csr_ready is always high. Write only while the block is idle.
//  - A test walks the directions in order through one shared multiplier:
//    each direction takes five setup products, one product per covariate
//    term, a drain state and a compare state. The walk stops at the first
//    failing direction. req_ready stays low for the whole walk.
//  - rsp is held in an output register; a load or the next test is taken
//    while it waits. A finished test holds in its last state until the
//    output register is free, so a stalled receiver backs up the block.
//  - Synchronous reset clears the sequencer, the output valid and both
//    configuration registers. Table contents are undefined until loaded.
`default_nettype none

module halfplane_region_point_test_top #(
   parameter int MAX_DIRECTIONS = 16,
   parameter int MAX_COVARIATES = 8,
   parameter int FRAC_BITS      = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  hrpt_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output hrpt_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hrpt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hrpt_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import hrpt_pkg::*;

   // Address and counter widths follow from the table sizes.
   localparam int DAW   = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
   localparam int CVW   = (MAX_COVARIATES > 1) ? $clog2(MAX_COVARIATES) : 1;
   localparam int CDEP  = MAX_DIRECTIONS * MAX_COVARIATES;
   localparam int CAW   = (CDEP > 1) ? $clog2(CDEP) : 1;
   localparam int SW    = $clog2(MAX_COVARIATES + 6);
   localparam int CW    = 2 * VAL_W + $clog2(MAX_COVARIATES);
   localparam int SUMW  = (CW > DOT_W) ? CW : DOT_W;
   localparam int CMPW  = ((SUMW + FRAC_BITS > PROD_W) ? SUMW + FRAC_BITS : PROD_W) + 1;

   // Multiplier schedule inside one direction.
   localparam logic [SW-1:0] STEP_OX    = SW'(0);
   localparam logic [SW-1:0] STEP_OY    = SW'(1);
   localparam logic [SW-1:0] STEP_DX    = SW'(2);
   localparam logic [SW-1:0] STEP_GAIN  = SW'(3);
   localparam logic [SW-1:0] STEP_DY    = SW'(4);
   localparam logic [SW-1:0] STEP_TERM0 = SW'(5);

   // Sequencer and configuration.
   state_type               state_ff, state_in;
   logic [NDIR_W-1:0]       num_dir_ff, num_dir_in;
   logic [NCOV_W-1:0]       num_cov_ff, num_cov_in;
   logic [NDIR_W-1:0]       nd_ff, nd_in, nd_sat;
   logic [NCOV_W-1:0]       nc_ff, nc_in, nc_sat;
   logic [DAW-1:0]          k_ff, k_in;
   logic [CVW-1:0]          c_ff, c_in;
   logic [SW-1:0]           s_ff, s_in;
   logic [SW-1:0]           last_step;
   logic [CAW-1:0]          base_ff, base_in;
   tag_type                 tag_ff, tag_in;
   logic                    clr_acc;

   // Point and accumulators.
   logic signed [VAL_W-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [DOT_W-1:0]   acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic signed [CW-1:0]      acc_c_ff, acc_c_in;
   logic signed [PROD_W-1:0]  acc_g_ff, acc_g_in;
   logic signed [CMPW-1:0]    lhs_w, rhs_w;
   logic                      fail;

   // Shared multiplier.
   logic signed [OPA_W-1:0]   op_a;
   logic signed [OPB_W-1:0]   op_b;
   logic signed [PROD_W-1:0]  prod;

   // Result and output register.
   logic                    res_inside_ff, res_inside_in;
   logic [NDIR_W-1:0]       res_count_ff, res_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // Tables.
   dir_row_type             dir_mem [MAX_DIRECTIONS];
   logic signed [VAL_W-1:0] coef_mem [CDEP];
   logic signed [VAL_W-1:0] cov_mem [MAX_COVARIATES];
   dir_row_type             dir_rd_ff;
   logic signed [VAL_W-1:0] coef_rd_ff, cov_rd_ff;
   dir_row_type             dir_wdata;
   logic                    dir_we, coef_we, cov_we;
   logic [DAW-1:0]          dir_waddr;
   logic [CAW-1:0]          coef_waddr;
   logic [CVW-1:0]          cov_waddr;
   logic [CAW-1:0]          coef_raddr;

   logic                    req_fire, csr_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------
   // Configuration registers; only the low bits of the write data count.
   // ---------------------------------------------------------------------
   always_comb begin
      num_dir_in = num_dir_ff;
      num_cov_in = num_cov_ff;
      if (csr_fire) begin
         priority if (csr_index == CSR_NUM_DIRECTIONS) begin
            num_dir_in = csr_wdata[NDIR_W-1:0];
         end else if (csr_index == CSR_NUM_COVARIATES) begin
            num_cov_in = csr_wdata[NCOV_W-1:0];
         end else begin
            num_dir_in = num_dir_ff;   // unknown index: drop the write
         end
      end
   end

   // Clamp the counts to the table sizes.
   always_comb begin
      nd_sat = num_dir_ff;
      nc_sat = num_cov_ff;
      if (32'(num_dir_ff) > MAX_DIRECTIONS) begin
         nd_sat = NDIR_W'(MAX_DIRECTIONS);
      end
      if (32'(num_cov_ff) > MAX_COVARIATES) begin
         nc_sat = NCOV_W'(MAX_COVARIATES);
      end
   end

   // ---------------------------------------------------------------------
   // Table loads: accepted in idle, dropped when the index is off the table.
   // ---------------------------------------------------------------------
   assign dir_we  = req_fire && (req_data.cmd == CMD_LOAD_DIR)
                    && (32'(req_data.dir_index) < MAX_DIRECTIONS);
   assign coef_we = req_fire && (req_data.cmd == CMD_LOAD_COEF)
                    && (32'(req_data.dir_index) < MAX_DIRECTIONS)
                    && (32'(req_data.cov_index) < MAX_COVARIATES);
   assign cov_we  = req_fire && (req_data.cmd == CMD_LOAD_COV)
                    && (32'(req_data.cov_index) < MAX_COVARIATES);

   assign dir_waddr  = DAW'(req_data.dir_index);
   assign coef_waddr = CAW'(32'(req_data.dir_index) * 32'(MAX_COVARIATES)
                            + 32'(req_data.cov_index));
   assign cov_waddr  = CVW'(req_data.cov_index);

   assign dir_wdata.dir_x    = req_data.dir_x;
   assign dir_wdata.dir_y    = req_data.dir_y;
   assign dir_wdata.orth_x   = req_data.orth_x;
   assign dir_wdata.orth_y   = req_data.orth_y;
   assign dir_wdata.eff_gain = req_data.eff_gain;

   // Read at the next address so the read register tracks the live index.
   assign coef_raddr = base_in + CAW'(c_in);

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= dir_wdata;
      end
      dir_rd_ff <= dir_mem[k_in];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= req_data.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (cov_we) begin
         cov_mem[cov_waddr] <= req_data.coef_value;
      end
      cov_rd_ff <= cov_mem[c_in];
   end

   // ---------------------------------------------------------------------
   // Operand select for the shared multiplier.
   // Orthogonal terms go first so the gain product can use their sum.
   // ---------------------------------------------------------------------
   always_comb begin
      op_a   = dir_rd_ff.orth_x;
      op_b   = OPB_W'(px_ff);
      tag_in = TAG_NONE;
      if (state_ff == S_MUL) begin
         priority if (s_ff == STEP_OX) begin
            op_a   = dir_rd_ff.orth_x;
            op_b   = OPB_W'(px_ff);
            tag_in = TAG_B;
         end else if (s_ff == STEP_OY) begin
            op_a   = dir_rd_ff.orth_y;
            op_b   = OPB_W'(py_ff);
            tag_in = TAG_B;
         end else if (s_ff == STEP_DX) begin
            op_a   = dir_rd_ff.dir_x;
            op_b   = OPB_W'(px_ff);
            tag_in = TAG_A;
         end else if (s_ff == STEP_GAIN) begin
            op_a   = dir_rd_ff.eff_gain;
            op_b   = acc_b_ff;
            tag_in = TAG_G;
         end else if (s_ff == STEP_DY) begin
            op_a   = dir_rd_ff.dir_y;
            op_b   = OPB_W'(py_ff);
            tag_in = TAG_A;
         end else begin
            op_a   = cov_rd_ff;
            op_b   = OPB_W'(coef_rd_ff);
            tag_in = TAG_C;
         end
      end
   end

   hrpt_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   // Accumulate the registered product in the next cycle, steered by the registered tag.
   always_comb begin
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      acc_c_in = acc_c_ff;
      acc_g_in = acc_g_ff;
      if (clr_acc) begin
         acc_a_in = '0;
         acc_b_in = '0;
         acc_c_in = '0;
      end else begin
         unique case (tag_ff)
            TAG_A:    acc_a_in = acc_a_ff + DOT_W'(prod);
            TAG_B:    acc_b_in = acc_b_ff + DOT_W'(prod);
            TAG_C:    acc_c_in = acc_c_ff + CW'(prod);
            TAG_G:    acc_g_in = prod;
            TAG_NONE: acc_a_in = acc_a_ff;
            default:  acc_a_in = acc_a_ff;
         endcase
      end
   end

   // Exact compare at 3*FRAC_BITS fraction bits: lhs = d.p, rhs = g*(o.p) + x.beta.
   assign lhs_w = CMPW'(acc_a_ff) <<< FRAC_BITS;
   assign rhs_w = CMPW'(acc_g_ff) + (CMPW'(acc_c_ff) <<< FRAC_BITS);
   assign fail  = (lhs_w < rhs_w);

   assign last_step = STEP_DY + SW'(nc_ff);

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      nd_in         = nd_ff;
      nc_in         = nc_ff;
      k_in          = k_ff;
      c_in          = c_ff;
      s_in          = s_ff;
      base_in       = base_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      clr_acc       = 1'b0;
      res_inside_in = res_inside_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_data.cmd == CMD_TEST)) begin
               px_in   = req_data.point_x;
               py_in   = req_data.point_y;
               nd_in   = nd_sat;
               nc_in   = nc_sat;
               k_in    = '0;
               c_in    = '0;
               s_in    = '0;
               base_in = '0;
               clr_acc = 1'b1;
               if (nd_sat == '0) begin
                  // no directions: outside, nothing examined
                  res_inside_in = 1'b0;
                  res_count_in  = '0;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end

         S_MUL: begin
            s_in = s_ff + SW'(1);
            if (s_ff >= STEP_TERM0) begin
               c_in = c_ff + CVW'(1);
            end
            if (s_ff == last_step) begin
               state_in = S_DRAIN;
            end
         end

         S_DRAIN: begin
            state_in = S_CMP;
         end

         S_CMP: begin
            res_count_in = NDIR_W'(32'(k_ff) + 32'd1);
            priority if (fail) begin
               res_inside_in = 1'b0;
               state_in      = S_DONE;
            end else if (32'(k_ff) + 32'd1 == 32'(nd_ff)) begin
               res_inside_in = 1'b1;
               state_in      = S_DONE;
            end else begin
               k_in     = k_ff + DAW'(1);
               base_in  = base_ff + CAW'(MAX_COVARIATES);
               c_in     = '0;
               s_in     = '0;
               clr_acc  = 1'b1;
               state_in = S_MUL;
            end
         end

         S_DONE: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_in.inside_res             = res_inside_ff;
               rsp_in.directions_examined    = res_count_ff;
               state_in                      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         num_dir_ff   <= '0;
         num_cov_ff   <= '0;
         tag_ff       <= TAG_NONE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         num_dir_ff   <= num_dir_in;
         num_cov_ff   <= num_cov_in;
         tag_ff       <= tag_in;
      end
   end

   // Datapath and counters; every use is qualified by the sequencer state.
   always_ff @(posedge clock) begin
      nd_ff         <= nd_in;
      nc_ff         <= nc_in;
      k_ff          <= k_in;
      c_ff          <= c_in;
      s_ff          <= s_in;
      base_ff       <= base_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      acc_a_ff      <= acc_a_in;
      acc_b_ff      <= acc_b_in;
      acc_c_ff      <= acc_c_in;
      acc_g_ff      <= acc_g_in;
      res_inside_ff <= res_inside_in;
      res_count_ff  <= res_count_in;
      rsp_ff        <= rsp_in;
   end

`ifndef SYNTHESIS
   // The compare only ever looks at a direction in use.
   a_cmp_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (32'(k_ff) < 32'(nd_ff)))
      else $error("compare on a direction past the count in use");

   // The step counter never runs past the last covariate term.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (s_ff <= last_step))
      else $error("multiplier step past the last term");

   // Leaving the final state always presents a response.
   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid_ff)
      else $error("finished test lost its response");

   // An inside verdict needs at least one examined direction.
   a_inside_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.inside_res) |-> (rsp_ff.directions_examined != '0))
      else $error("inside verdict with no direction examined");
`endif

endmodule

`default_nettype wire
